>>> hw/rtl/mgd_pkg.sv
// Shared types and constants for the mouse gesture detector.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mgd_pkg;

  // Default pointer coordinate width.
  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned BUTTON_BITS = 4;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned TOL_BITS    = 8;
  localparam int unsigned WIN_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOW_BOXING = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_TOL    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DBL_WINDOW   = 2'd2;

  // Configuration reset values.
  localparam logic [TOL_BITS-1:0] CLICK_TOL_RST  = 8'd3;
  localparam logic [WIN_BITS-1:0] DBL_WINDOW_RST = 16'd400;

  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_DOWN   = 2'd1,
    REQ_UP     = 2'd2,
    REQ_CANCEL = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    EV_CLICK  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_BOX    = 2'd2
  } event_kind_e;

  // Which results one input word produces, in delivery order click, double, box.
  typedef struct packed {
    logic click;
    logic dbl;
    logic box;
  } res_set_t;

endpackage

`default_nettype wire

>>> hw/rtl/mgd_state.sv
// Gesture state and decision logic: configuration registers, press tracking,
// boxing flags and click timing. Depends on mgd_pkg.
`default_nettype none

module mgd_state #(
  parameter int unsigned COORD_BITS = mgd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mgd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [mgd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire logic                               accept_i,
  input  wire logic [1:0]                         req_type_i,
  input  wire logic [COORD_BITS-1:0]              pos_x_i,
  input  wire logic [COORD_BITS-1:0]              pos_y_i,
  input  wire logic [mgd_pkg::BUTTON_BITS-1:0]    button_i,
  input  wire logic [mgd_pkg::TIME_BITS-1:0]      timestamp_ms_i,
  output mgd_pkg::res_set_t                       res_o,
  output logic [COORD_BITS-1:0]                   press_x_o,
  output logic [COORD_BITS-1:0]                   press_y_o,
  output logic [COORD_BITS-1:0]                   lo_x_o,
  output logic [COORD_BITS-1:0]                   lo_y_o,
  output logic [COORD_BITS-1:0]                   hi_x_o,
  output logic [COORD_BITS-1:0]                   hi_y_o,
  output logic [mgd_pkg::BUTTON_BITS-1:0]         button_o
);

  logic                              allow_boxing_q;
  logic [mgd_pkg::TOL_BITS-1:0]      click_tol_q;
  logic [mgd_pkg::WIN_BITS-1:0]      dbl_window_q;

  logic [COORD_BITS-1:0]             press_x_q, press_x_d;
  logic [COORD_BITS-1:0]             press_y_q, press_y_d;
  logic [mgd_pkg::BUTTON_BITS-1:0]   held_q, held_d;
  logic                              active_q, active_d;
  logic                              blocked_q, blocked_d;
  logic [mgd_pkg::TIME_BITS-1:0]     last_click_q, last_click_d;
  logic [mgd_pkg::TIME_BITS-1:0]     last_dbl_q, last_dbl_d;

  logic [COORD_BITS-1:0]             dx, dy, tol_ext;
  logic [mgd_pkg::TIME_BITS-1:0]     dt_click, dt_dbl, win_ext;
  logic                              near, in_window, dbl_stale;
  mgd_pkg::res_set_t                 res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_boxing_q <= 1'b0;
      click_tol_q    <= mgd_pkg::CLICK_TOL_RST;
      dbl_window_q   <= mgd_pkg::DBL_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mgd_pkg::CFG_ALLOW_BOXING: allow_boxing_q <= cfg_wdata_i[0];
        mgd_pkg::CFG_CLICK_TOL:    click_tol_q    <= cfg_wdata_i[mgd_pkg::TOL_BITS-1:0];
        mgd_pkg::CFG_DBL_WINDOW:   dbl_window_q   <= cfg_wdata_i[mgd_pkg::WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign dx = (press_x_q > pos_x_i) ? press_x_q - pos_x_i : pos_x_i - press_x_q;
  assign dy = (press_y_q > pos_y_i) ? press_y_q - pos_y_i : pos_y_i - press_y_q;
  assign tol_ext = COORD_BITS'(click_tol_q);
  assign near = (dx < tol_ext) && (dy < tol_ext);

  // Time differences wrap modulo 2^32.
  assign win_ext   = mgd_pkg::TIME_BITS'(dbl_window_q);
  assign dt_click  = timestamp_ms_i - last_click_q;
  assign dt_dbl    = timestamp_ms_i - last_dbl_q;
  assign in_window = dt_click < win_ext;
  assign dbl_stale = dt_dbl > win_ext;

  always_comb begin
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    held_d       = held_q;
    active_d     = active_q;
    blocked_d    = blocked_q;
    last_click_d = last_click_q;
    last_dbl_d   = last_dbl_q;
    res          = '0;
    unique case (mgd_pkg::req_type_e'(req_type_i))
      mgd_pkg::REQ_MOVE: begin
        if (held_q != '0 && allow_boxing_q && !blocked_q) begin
          active_d = 1'b1;
        end
        if (!allow_boxing_q) begin
          active_d = 1'b0;
        end
      end
      mgd_pkg::REQ_DOWN: begin
        press_x_d = pos_x_i;
        press_y_d = pos_y_i;
        held_d    = button_i;
      end
      mgd_pkg::REQ_UP: begin
        blocked_d = 1'b0;
        if (held_q == button_i) begin
          if (near) begin
            res.click    = 1'b1;
            last_click_d = timestamp_ms_i;
            if (in_window && dbl_stale) begin
              res.dbl    = 1'b1;
              last_dbl_d = timestamp_ms_i;
            end
          end
          if (active_q) begin
            res.box  = 1'b1;
            active_d = 1'b0;
          end
          held_d = '0;
        end
      end
      mgd_pkg::REQ_CANCEL: begin
        active_d  = 1'b0;
        blocked_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_x_q    <= '0;
      press_y_q    <= '0;
      held_q       <= '0;
      active_q     <= 1'b0;
      blocked_q    <= 1'b0;
      last_click_q <= '0;
      last_dbl_q   <= '0;
    end else if (accept_i) begin
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      held_q       <= held_d;
      active_q     <= active_d;
      blocked_q    <= blocked_d;
      last_click_q <= last_click_d;
      last_dbl_q   <= last_dbl_d;
    end
  end

  assign res_o     = res;
  assign press_x_o = press_x_q;
  assign press_y_o = press_y_q;
  assign lo_x_o    = (press_x_q < pos_x_i) ? press_x_q : pos_x_i;
  assign lo_y_o    = (press_y_q < pos_y_i) ? press_y_q : pos_y_i;
  assign hi_x_o    = (press_x_q > pos_x_i) ? press_x_q : pos_x_i;
  assign hi_y_o    = (press_y_q > pos_y_i) ? press_y_q : pos_y_i;
  assign button_o  = button_i;

endmodule

`default_nettype wire

>>> hw/rtl/mgd_drain.sv
// Result set register and output register: holds the results of one input
// word and hands them out one word per cycle unless stalled. Depends on mgd_pkg.
`default_nettype none

module mgd_drain #(
  parameter int unsigned COORD_BITS = mgd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire mgd_pkg::res_set_t                  res_i,
  input  wire logic [COORD_BITS-1:0]              press_x_i,
  input  wire logic [COORD_BITS-1:0]              press_y_i,
  input  wire logic [COORD_BITS-1:0]              lo_x_i,
  input  wire logic [COORD_BITS-1:0]              lo_y_i,
  input  wire logic [COORD_BITS-1:0]              hi_x_i,
  input  wire logic [COORD_BITS-1:0]              hi_y_i,
  input  wire logic [mgd_pkg::BUTTON_BITS-1:0]    button_i,
  output logic                                    can_take_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              event_kind_o,
  output logic [COORD_BITS-1:0]                   first_x_o,
  output logic [COORD_BITS-1:0]                   first_y_o,
  output logic [COORD_BITS-1:0]                   second_x_o,
  output logic [COORD_BITS-1:0]                   second_y_o,
  output logic [mgd_pkg::BUTTON_BITS-1:0]         event_button_o,
  output logic                                    last_of_run_o
);

  mgd_pkg::res_set_t                 pend_q, pend_d, rest;
  logic [COORD_BITS-1:0]             px_q, py_q, lx_q, ly_q, hx_q, hy_q;
  logic [mgd_pkg::BUTTON_BITS-1:0]   btn_q;

  logic                              out_valid_q;
  mgd_pkg::event_kind_e              kind_q, kind_sel;
  logic [COORD_BITS-1:0]             fx_q, fy_q, sx_q, sy_q;
  logic [mgd_pkg::BUTTON_BITS-1:0]   obtn_q;
  logic                              last_q;
  logic                              out_load;

  // Pick the earliest pending result and what remains after it.
  always_comb begin
    rest = pend_q;
    kind_sel = mgd_pkg::EV_BOX;
    priority if (pend_q.click) begin
      kind_sel   = mgd_pkg::EV_CLICK;
      rest.click = 1'b0;
    end else if (pend_q.dbl) begin
      kind_sel = mgd_pkg::EV_DOUBLE;
      rest.dbl = 1'b0;
    end else begin
      kind_sel = mgd_pkg::EV_BOX;
      rest.box = 1'b0;
    end
  end

  assign out_load   = (pend_q != '0) && (!out_valid_q || !out_stall_i);
  assign can_take_o = (pend_q == '0) || (out_load && (rest == '0));

  always_comb begin
    pend_d = pend_q;
    if (out_load) begin
      pend_d = rest;
    end
    if (accept_i) begin
      pend_d = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      px_q  <= press_x_i;
      py_q  <= press_y_i;
      lx_q  <= lo_x_i;
      ly_q  <= lo_y_i;
      hx_q  <= hi_x_i;
      hy_q  <= hi_y_i;
      btn_q <= button_i;
    end
    if (out_load) begin
      kind_q <= kind_sel;
      obtn_q <= btn_q;
      last_q <= (rest == '0);
      if (kind_sel == mgd_pkg::EV_BOX) begin
        fx_q <= lx_q;
        fy_q <= ly_q;
        sx_q <= hx_q;
        sy_q <= hy_q;
      end else begin
        fx_q <= px_q;
        fy_q <= py_q;
        sx_q <= px_q;
        sy_q <= py_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign first_x_o      = fx_q;
  assign first_y_o      = fy_q;
  assign second_x_o     = sx_q;
  assign second_y_o     = sy_q;
  assign event_button_o = obtn_q;
  assign last_of_run_o  = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/mouse_gesture_detector_core.sv
// Top level of the mouse gesture detector: pointer events in, click,
// double-click and box results out. Depends on mgd_pkg, mgd_state, mgd_drain.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   req_type, pos_x/y, button, timestamp_ms
//   out      output     out_valid_o / out_stall_i event_kind, first/second x/y,
//                                                 event_button, last_of_run
//   cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// An input word is decided in the cycle it is accepted: the gesture state
// updates at that edge and its results (zero to three) land in a result set
// register. The output register then takes one result per cycle while the
// output is not stalled, so a result passes the result set register and then
// the output register, and a word that causes n results yields n output words.
// Words that cause zero or one result are accepted every cycle while the
// output is not stalled; a new word is accepted as soon as the last pending
// result of the previous one moves to the output register, so a word that
// causes several results holds off the next word until they have all moved.
// Reset (asynchronous, active low) clears the gesture state, the pending
// results and the output valid, and returns the configuration to boxing
// off, tolerance 3 and a 400 ms window. A stall on the output holds the
// output word and, once the result set register is full, stalls the input.
// The current pointer position is not kept in a register; the position of
// a release word feeds the click tolerance check and the box corners.
`default_nettype none

module mouse_gesture_detector_core #(
  parameter int unsigned COORD_BITS = mgd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mgd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [mgd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         req_type_i,
  input  wire logic [COORD_BITS-1:0]              pos_x_i,
  input  wire logic [COORD_BITS-1:0]              pos_y_i,
  input  wire logic [mgd_pkg::BUTTON_BITS-1:0]    button_i,
  input  wire logic [mgd_pkg::TIME_BITS-1:0]      timestamp_ms_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              event_kind_o,
  output logic [COORD_BITS-1:0]                   first_x_o,
  output logic [COORD_BITS-1:0]                   first_y_o,
  output logic [COORD_BITS-1:0]                   second_x_o,
  output logic [COORD_BITS-1:0]                   second_y_o,
  output logic [mgd_pkg::BUTTON_BITS-1:0]         event_button_o,
  output logic                                    last_of_run_o
);

  mgd_pkg::res_set_t                 res;
  logic [COORD_BITS-1:0]             press_x, press_y, lo_x, lo_y, hi_x, hi_y;
  logic [mgd_pkg::BUTTON_BITS-1:0]   rel_button;
  logic                              can_take;
  logic                              in_accept;

  // The input is taken whenever the result set register will be free.
  assign in_stall_o = !can_take;
  assign in_accept  = in_valid_i && can_take;

  mgd_state #(
    .COORD_BITS(COORD_BITS)
  ) u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (in_accept),
    .req_type_i     (req_type_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .button_i       (button_i),
    .timestamp_ms_i (timestamp_ms_i),
    .res_o          (res),
    .press_x_o      (press_x),
    .press_y_o      (press_y),
    .lo_x_o         (lo_x),
    .lo_y_o         (lo_y),
    .hi_x_o         (hi_x),
    .hi_y_o         (hi_y),
    .button_o       (rel_button)
  );

  mgd_drain #(
    .COORD_BITS(COORD_BITS)
  ) u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .res_i          (res),
    .press_x_i      (press_x),
    .press_y_i      (press_y),
    .lo_x_i         (lo_x),
    .lo_y_i         (lo_y),
    .hi_x_i         (hi_x),
    .hi_y_i         (hi_y),
    .button_i       (rel_button),
    .can_take_o     (can_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .first_x_o      (first_x_o),
    .first_y_o      (first_y_o),
    .second_x_o     (second_x_o),
    .second_y_o     (second_y_o),
    .event_button_o (event_button_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mgd_checker.sv
// Port-level checker for the mouse gesture detector and its bind to the top
// level. Depends on mgd_pkg and mouse_gesture_detector_core.
`default_nettype none

module mgd_checker #(
  parameter int unsigned COORD_BITS = mgd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  input  wire logic [1:0]                         event_kind_o,
  input  wire logic [COORD_BITS-1:0]              first_x_o,
  input  wire logic [COORD_BITS-1:0]              first_y_o,
  input  wire logic [COORD_BITS-1:0]              second_x_o,
  input  wire logic [COORD_BITS-1:0]              second_y_o,
  input  wire logic [mgd_pkg::BUTTON_BITS-1:0]    event_button_o,
  input  wire logic                               last_of_run_o
);

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(first_x_o) && $stable(first_y_o) && $stable(second_x_o)
      && $stable(second_y_o) && $stable(event_button_o) && $stable(last_of_run_o))
    else $error("stalled result word changed");

  // Clicks and double-clicks report a single point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == mgd_pkg::EV_CLICK || event_kind_o == mgd_pkg::EV_DOUBLE)
      |-> first_x_o == second_x_o && first_y_o == second_y_o)
    else $error("click result with two different corners");

  // A box has its smaller corner first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == mgd_pkg::EV_BOX
      |-> first_x_o <= second_x_o && first_y_o <= second_y_o)
    else $error("box corners out of order");

  // A box is always the final result of its event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == mgd_pkg::EV_BOX |-> last_of_run_o)
    else $error("box result not marked last");

endmodule

bind mouse_gesture_detector_core mgd_checker #(
  .COORD_BITS(COORD_BITS)
) u_mgd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .event_kind_o   (event_kind_o),
  .first_x_o      (first_x_o),
  .first_y_o      (first_y_o),
  .second_x_o     (second_x_o),
  .second_y_o     (second_y_o),
  .event_button_o (event_button_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire
